>>> hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Default number of transmit buffer slots.
  localparam int unsigned SEND_DEPTH_DEF = 16;

  // Operation carried by an input word.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_STATUS = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Command handed to the byte-level bus controller.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_NACK  = 3'd3,
    CMD_ACK   = 3'd4
  } cmd_e;

  // Bus controller status codes, compared after masking the low three bits.
  localparam logic [7:0] STATUS_MASK      = 8'hF8;
  localparam logic [7:0] ST_START         = 8'h08;
  localparam logic [7:0] ST_RESTART       = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK    = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NACK   = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK    = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK   = 8'h30;
  localparam logic [7:0] ST_ADDR_R_ACK    = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NACK   = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK    = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK   = 8'h58;

  // One input word.
  typedef struct packed {
    op_e        operation;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic [6:0] target_address;
    logic [4:0] write_length;
    logic [7:0] read_length;
    logic [7:0] bus_status;
    logic [7:0] bus_data_in;
  } item_t;

  // One result word.
  typedef struct packed {
    cmd_e       bus_command;
    logic       data_write_valid;
    logic [7:0] data_write_byte;
    logic       read_valid;
    logic [7:0] read_index;
    logic [7:0] read_byte;
    logic       write_done;
    logic       read_done;
    logic       bus_error;
  } result_t;

endpackage

>>> hdl/i2cms_in_stage.sv
// ----------------------------------------------------------------------------
// i2cms_in_stage
// Input register: captures one word and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module i2cms_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cms_pkg::item_t    item_i,
  input  logic                take_i,
  output logic                valid_o,
  output i2cms_pkg::item_t    item_o
);
  import i2cms_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The held word blocks a new one only while the engine cannot take it.
  assign in_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/i2cms_engine.sv
// ----------------------------------------------------------------------------
// i2cms_engine
// Transaction state, transmit buffer and the per-word decode of one step.
// ----------------------------------------------------------------------------
module i2cms_engine #(
  parameter int unsigned SEND_DEPTH = i2cms_pkg::SEND_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  i2cms_pkg::item_t    item_i,
  output i2cms_pkg::result_t  result_o
);
  import i2cms_pkg::*;

  // Only the slots a four-bit index can reach are ever written.
  localparam int unsigned BufDepth = (SEND_DEPTH < 16) ? SEND_DEPTH : 16;
  localparam int unsigned BufIdxW  = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  // A five-bit length is clipped to SEND_DEPTH, and to 31 at most.
  localparam int unsigned SatLen   = (SEND_DEPTH < 31) ? SEND_DEPTH : 31;

  logic       read_mode_q, read_mode_d;
  logic [4:0] send_pos_q, send_pos_d;
  logic [4:0] send_total_q, send_total_d;
  logic [7:0] recv_pos_q, recv_pos_d;
  logic [7:0] recv_total_q, recv_total_d;
  logic [6:0] peer_addr_q, peer_addr_d;
  logic [7:0] send_buf_q [BufDepth];

  logic [7:0] status;
  logic [7:0] recv_last;
  logic [7:0] slot_byte;
  logic [4:0] send_pos_inc;
  logic [4:0] wr_len;
  result_t    res;

  assign status       = item_i.bus_status & STATUS_MASK;
  assign recv_last    = recv_total_q - 8'd2;
  assign send_pos_inc = send_pos_q + 5'd1;
  assign slot_byte    = (send_pos_q < 5'(BufDepth)) ?
                        send_buf_q[send_pos_q[BufIdxW-1:0]] : 8'd0;
  assign wr_len       = (item_i.write_length > 5'(SatLen)) ?
                        5'(SatLen) : item_i.write_length;

  always_comb begin
    res          = '0;
    read_mode_d  = read_mode_q;
    send_pos_d   = send_pos_q;
    send_total_d = send_total_q;
    recv_pos_d   = recv_pos_q;
    recv_total_d = recv_total_q;
    peer_addr_d  = peer_addr_q;

    unique case (item_i.operation)
      OP_START: begin
        if (item_i.write_length == 5'd0 && item_i.read_length == 8'd0) begin
          // Nothing to move: report both phases done at once.
          res.write_done = 1'b1;
          res.read_done  = 1'b1;
        end else begin
          send_pos_d      = 5'd0;
          recv_pos_d      = 8'd0;
          send_total_d    = wr_len;
          recv_total_d    = item_i.read_length;
          peer_addr_d     = item_i.target_address;
          read_mode_d     = (wr_len == 5'd0);
          res.bus_command = CMD_START;
        end
      end
      OP_STATUS: begin
        unique case (status) inside
          ST_START, ST_RESTART: begin
            res.data_write_valid = 1'b1;
            res.data_write_byte  = {peer_addr_q, read_mode_q};
            res.bus_command      = CMD_NACK;
          end
          ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
            if (send_pos_q < send_total_q) begin
              res.data_write_valid = 1'b1;
              res.data_write_byte  = slot_byte;
              res.bus_command      = CMD_NACK;
              res.write_done       = (send_pos_inc == send_total_q);
              send_pos_d           = send_pos_inc;
            end else if (status == ST_DATA_W_ACK) begin
              if (recv_total_q == 8'd0) begin
                res.bus_command = CMD_STOP;
              end else begin
                res.bus_command = CMD_START;
                read_mode_d     = 1'b1;
              end
            end
          end
          ST_ADDR_R_ACK: begin
            res.bus_command = (recv_total_q <= 8'd1) ? CMD_NACK : CMD_ACK;
          end
          ST_DATA_R_ACK: begin
            if (recv_total_q >= 8'd2 && recv_pos_q <= recv_last) begin
              res.read_valid  = 1'b1;
              res.read_index  = recv_pos_q;
              res.read_byte   = item_i.bus_data_in;
              res.bus_command = (recv_pos_q == recv_last) ? CMD_NACK : CMD_ACK;
              recv_pos_d      = recv_pos_q + 8'd1;
            end
          end
          ST_DATA_R_NACK: begin
            res.read_valid  = 1'b1;
            res.read_index  = recv_pos_q;
            res.read_byte   = item_i.bus_data_in;
            res.bus_command = CMD_STOP;
            res.read_done   = 1'b1;
          end
          ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ADDR_R_NACK: begin
            res.bus_command = CMD_STOP;
            res.bus_error   = 1'b1;
          end
          default: begin
          end
        endcase
      end
      OP_LOAD, OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_mode_q  <= 1'b0;
      send_pos_q   <= 5'd0;
      send_total_q <= 5'd0;
      recv_pos_q   <= 8'd0;
      recv_total_q <= 8'd0;
      peer_addr_q  <= 7'd0;
    end else if (fire_i) begin
      read_mode_q  <= read_mode_d;
      send_pos_q   <= send_pos_d;
      send_total_q <= send_total_d;
      recv_pos_q   <= recv_pos_d;
      recv_total_q <= recv_total_d;
      peer_addr_q  <= peer_addr_d;
    end
  end

  // Transmit buffer; slots beyond the depth are dropped.
  always_ff @(posedge clk_i) begin
    if (fire_i && item_i.operation == OP_LOAD &&
        {1'b0, item_i.byte_index} < 5'(BufDepth)) begin
      send_buf_q[item_i.byte_index[BufIdxW-1:0]] <= item_i.byte_value;
    end
  end

  assign result_o = res;

  // The send pointer never runs past the number of bytes to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_pos_q <= send_total_q)
    else $error("send position beyond send total");

  // A received byte always comes with an acknowledge choice or a stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.read_valid |->
      (res.bus_command == CMD_ACK || res.bus_command == CMD_NACK ||
       res.bus_command == CMD_STOP))
    else $error("received byte without a bus command");

  // Write done alone marks the last data byte, which is then loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.write_done && !res.read_done |-> res.data_write_valid)
    else $error("write done without a loaded byte");

endmodule

>>> hdl/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Steps an I2C master through an optional write phase and an optional read
// phase joined by a repeated start, one bus event per word.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   input     in_valid_i / in_stall_o   operation_i .. bus_data_in_i
//   output    out_valid_o / out_stall_i bus_command_o .. bus_error_o
//
// A word is taken every cycle when the output side does not stall; each
// input word gives exactly one output word, via the input and output registers.
// The step logic sits between the input register and the output register;
// the transaction state updates as a word moves into the output register.
// Reset clears the valid flags and the transaction state; the transmit
// buffer is not cleared and must be loaded before it is sent.
// A stall at the output holds the output word; the input register takes one
// more word only if it is empty, then the input stalls as well.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
  parameter int unsigned SEND_DEPTH = i2cms_pkg::SEND_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [3:0] byte_index_i,
  input  logic [7:0] byte_value_i,
  input  logic [6:0] target_address_i,
  input  logic [4:0] write_length_i,
  input  logic [7:0] read_length_i,
  input  logic [7:0] bus_status_i,
  input  logic [7:0] bus_data_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] bus_command_o,
  output logic       data_write_valid_o,
  output logic [7:0] data_write_byte_o,
  output logic       read_valid_o,
  output logic [7:0] read_index_o,
  output logic [7:0] read_byte_o,
  output logic       write_done_o,
  output logic       read_done_o,
  output logic       bus_error_o
);
  import i2cms_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_ready;
  logic    fire;
  result_t step_res;
  logic    out_valid_q;
  result_t out_q;

  // Pack the input ports into one word.
  always_comb begin
    in_item.operation      = op_e'(operation_i);
    in_item.byte_index     = byte_index_i;
    in_item.byte_value     = byte_value_i;
    in_item.target_address = target_address_i;
    in_item.write_length   = write_length_i;
    in_item.read_length    = read_length_i;
    in_item.bus_status     = bus_status_i;
    in_item.bus_data_in    = bus_data_in_i;
  end

  // The output register can load when it is empty or being drained.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign fire      = held_valid && out_ready;

  i2cms_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (out_ready),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  i2cms_engine #(
    .SEND_DEPTH (SEND_DEPTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (held_item),
    .result_o (step_res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= held_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign bus_command_o      = out_q.bus_command;
  assign data_write_valid_o = out_q.data_write_valid;
  assign data_write_byte_o  = out_q.data_write_byte;
  assign read_valid_o       = out_q.read_valid;
  assign read_index_o       = out_q.read_index;
  assign read_byte_o        = out_q.read_byte;
  assign write_done_o       = out_q.write_done;
  assign read_done_o        = out_q.read_done;
  assign bus_error_o        = out_q.bus_error;

endmodule
